[hdl/rht_pkg.sv]
// ----------------------------------------------------------------------------
// rht_pkg
// shared types and constants of the reference counted handle table
// ----------------------------------------------------------------------------
package rht_pkg;

	localparam int unsigned HANDLE_W = 31;
	localparam int unsigned STATUS_W = 3;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_PURGE  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_INCREMENTED = 3'd0,
		STS_INSERTED    = 3'd1,
		STS_FULL        = 3'd2,
		STS_DECREMENTED = 3'd3,
		STS_RELEASED    = 3'd4,
		STS_NOT_FOUND   = 3'd5,
		STS_PURGE_ENTRY = 3'd6,
		STS_PURGE_EMPTY = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD,
		ST_PURGE
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_CMP,
		OP_ADD_HIT,
		OP_INSERT,
		OP_DEC_HIT,
		OP_REMOVE,
		OP_PURGE
	} cell_op_t;

	// broadcast from the controller to every cell of the row
	typedef struct packed {
		cell_op_t              op;
		logic [HANDLE_W-1:0]   key;
	} cell_ctrl_t;

endpackage

[hdl/rht_cell.sv]
// ----------------------------------------------------------------------------
// rht_cell
// one table slot: handle, count, match flag and shift-down from the neighbour
// ----------------------------------------------------------------------------
module rht_cell #(
	parameter int unsigned IDX         = 0,
	parameter int unsigned COUNT_WIDTH = 16,
	parameter int unsigned OCC_WIDTH   = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rht_pkg::cell_ctrl_t           ctrl,
	input  logic [OCC_WIDTH-1:0]          occupancy,
	input  logic [rht_pkg::HANDLE_W-1:0]  up_handle,
	input  logic [COUNT_WIDTH-1:0]        up_count,
	input  logic                          below_hit,
	output logic                          upto_hit,
	output logic                          hit,
	output logic [rht_pkg::HANDLE_W-1:0]  cur_handle,
	output logic [COUNT_WIDTH-1:0]        cur_count
);

	localparam logic [OCC_WIDTH-1:0]   SLOT      = OCC_WIDTH'(IDX);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic                          hit_s1;
	logic [rht_pkg::HANDLE_W-1:0]  handle_q;
	logic [COUNT_WIDTH-1:0]        count_q;
	logic                          occupied;

	assign occupied   = (SLOT < occupancy);
	assign upto_hit   = below_hit | hit_s1;
	assign hit        = hit_s1;
	assign cur_handle = handle_q;
	assign cur_count  = count_q;

	// match flag, held from the compare pass into the update pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (ctrl.op == rht_pkg::OP_CMP) begin
			hit_s1 <= occupied && (handle_q == ctrl.key);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			rht_pkg::OP_HOLD, rht_pkg::OP_CMP: begin
			end
			rht_pkg::OP_ADD_HIT: begin
				if (hit_s1 && (count_q != COUNT_MAX)) begin
					count_q <= count_q + 1'b1;
				end
			end
			rht_pkg::OP_INSERT: begin
				if (SLOT == occupancy) begin
					handle_q <= ctrl.key;
					count_q  <= COUNT_WIDTH'(1);
				end
			end
			rht_pkg::OP_DEC_HIT: begin
				if (hit_s1) begin
					count_q <= count_q - 1'b1;
				end
			end
			rht_pkg::OP_REMOVE: begin
				// close the gap from the removed slot upwards
				if (upto_hit) begin
					handle_q <= up_handle;
					count_q  <= up_count;
				end
			end
			rht_pkg::OP_PURGE: begin
				handle_q <= up_handle;
				count_q  <= up_count;
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/refcount_handle_table_unit.sv]
// ----------------------------------------------------------------------------
// refcount_handle_table_unit
// reference counted handle table built as a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Add and remove
// run in two passes: a compare pass in which every cell matches the handle in
// parallel, then an update pass in which the matched cell counts up or down,
// a new handle lands in the first free cell, or the cells above a released
// entry all shift down one place at once. busy is already low in the update
// pass, so the next add or remove can be taken during it. The result of each
// transaction appears on the result ports, marked by result_valid, for exactly
// one cycle, in the cycle after the update pass. A purge walks the table out
// through cell 0, one entry and one result per cycle, and keeps busy high
// until the last entry has left (an empty table gives a single purge-empty
// result). Command 3 is taken and dropped with no result.
// The receiver cannot stall the results; nothing here waits for it.
// ----------------------------------------------------------------------------
module refcount_handle_table_unit #(
	parameter int unsigned TABLE_DEPTH = 32,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          command,
	input  logic [rht_pkg::HANDLE_W-1:0]        handle,
	output logic                                result_valid,
	output logic [rht_pkg::STATUS_W-1:0]        status,
	output logic                                release_valid,
	output logic [rht_pkg::HANDLE_W-1:0]        release_handle,
	output logic [COUNT_WIDTH-1:0]              ref_count,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]    entry_count,
	output logic                                last
);

	localparam int unsigned OCC_WIDTH = $clog2(TABLE_DEPTH + 1);
	localparam logic [OCC_WIDTH-1:0]   OCC_FULL  = OCC_WIDTH'(TABLE_DEPTH);
	localparam logic [OCC_WIDTH-1:0]   OCC_ONE   = OCC_WIDTH'(1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

	// control state
	rht_pkg::state_t                state_q, state_d;
	rht_pkg::cmd_t                  cmd_q;
	logic [rht_pkg::HANDLE_W-1:0]   handle_q;
	logic [OCC_WIDTH-1:0]           occ_q, occ_d;
	logic                           accept;

	// cell row
	rht_pkg::cell_ctrl_t            cell_ctrl;
	rht_pkg::cell_op_t              cell_op;
	logic [TABLE_DEPTH-1:0]         hit_vec;
	logic [TABLE_DEPTH-1:0]         upto_vec;
	logic [rht_pkg::HANDLE_W-1:0]   cell_handle [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0]         cell_count  [TABLE_DEPTH];
	logic                           found;
	logic [COUNT_WIDTH-1:0]         hit_count;

	// next result
	logic                           res_fire;
	rht_pkg::status_t               res_status;
	logic                           res_rv;
	logic [rht_pkg::HANDLE_W-1:0]   res_rh;
	logic [COUNT_WIDTH-1:0]         res_cnt;
	logic                           res_last;

	// result register
	logic                           result_valid_q;
	rht_pkg::status_t               status_q;
	logic                           release_valid_q;
	logic [rht_pkg::HANDLE_W-1:0]   release_handle_q;
	logic [COUNT_WIDTH-1:0]         ref_count_q;
	logic [OCC_WIDTH-1:0]           entry_count_q;
	logic                           last_q;

	// busy only while comparing or draining; the update pass overlaps intake
	assign busy   = (state_q == rht_pkg::ST_CMP) || (state_q == rht_pkg::ST_PURGE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rht_pkg::ST_IDLE;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= rht_pkg::cmd_t'(command);
			handle_q <= handle;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rht_pkg::ST_IDLE, rht_pkg::ST_UPD: begin
				state_d = rht_pkg::ST_IDLE;
				if (accept) begin
					unique case (rht_pkg::cmd_t'(command))
						rht_pkg::CMD_ADD, rht_pkg::CMD_REMOVE: state_d = rht_pkg::ST_CMP;
						rht_pkg::CMD_PURGE:                    state_d = rht_pkg::ST_PURGE;
						default:                               state_d = rht_pkg::ST_IDLE;
					endcase
				end
			end
			rht_pkg::ST_CMP: begin
				state_d = rht_pkg::ST_UPD;
			end
			rht_pkg::ST_PURGE: begin
				if (occ_q <= OCC_ONE) begin
					state_d = rht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rht_pkg::ST_IDLE;
			end
		endcase
	end

	// match summary over the row; entries are unique so an or is enough
	always_comb begin
		hit_count = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_count = hit_count | (cell_count[i] & {COUNT_WIDTH{hit_vec[i]}});
		end
	end
	assign found = |hit_vec;

	// cell operation, occupancy and result
	always_comb begin
		cell_op    = rht_pkg::OP_HOLD;
		occ_d      = occ_q;
		res_fire   = 1'b0;
		res_status = rht_pkg::STS_INCREMENTED;
		res_rv     = 1'b0;
		res_rh     = '0;
		res_cnt    = '0;
		res_last   = 1'b1;
		unique case (state_q)
			rht_pkg::ST_IDLE: begin
			end
			rht_pkg::ST_CMP: begin
				cell_op = rht_pkg::OP_CMP;
			end
			rht_pkg::ST_UPD: begin
				unique case (cmd_q)
					rht_pkg::CMD_ADD: begin
						res_fire = 1'b1;
						priority if (found) begin
							cell_op    = rht_pkg::OP_ADD_HIT;
							res_status = rht_pkg::STS_INCREMENTED;
							// saturating count
							res_cnt    = (hit_count == COUNT_MAX) ? hit_count
							                                      : hit_count + 1'b1;
						end else if (occ_q == OCC_FULL) begin
							res_status = rht_pkg::STS_FULL;
						end else begin
							cell_op    = rht_pkg::OP_INSERT;
							res_status = rht_pkg::STS_INSERTED;
							res_cnt    = COUNT_ONE;
							occ_d      = occ_q + 1'b1;
						end
					end
					rht_pkg::CMD_REMOVE: begin
						res_fire = 1'b1;
						priority if (!found) begin
							res_status = rht_pkg::STS_NOT_FOUND;
						end else if (hit_count > COUNT_ONE) begin
							cell_op    = rht_pkg::OP_DEC_HIT;
							res_status = rht_pkg::STS_DECREMENTED;
							res_cnt    = hit_count - 1'b1;
						end else begin
							cell_op    = rht_pkg::OP_REMOVE;
							res_status = rht_pkg::STS_RELEASED;
							res_rv     = 1'b1;
							res_rh     = handle_q;
							occ_d      = occ_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			rht_pkg::ST_PURGE: begin
				res_fire = 1'b1;
				if (occ_q == '0) begin
					res_status = rht_pkg::STS_PURGE_EMPTY;
				end else begin
					// cell 0 leaves, the rest move down one place
					cell_op    = rht_pkg::OP_PURGE;
					res_status = rht_pkg::STS_PURGE_ENTRY;
					res_rv     = 1'b1;
					res_rh     = cell_handle[0];
					res_last   = (occ_q == OCC_ONE);
					occ_d      = occ_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign cell_ctrl.op  = cell_op;
	assign cell_ctrl.key = handle_q;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic [rht_pkg::HANDLE_W-1:0]  up_handle;
		logic [COUNT_WIDTH-1:0]        up_count;
		logic                          below_hit;

		if (g == TABLE_DEPTH - 1) begin : g_top
			assign up_handle = cell_handle[g];
			assign up_count  = cell_count[g];
		end else begin : g_mid
			assign up_handle = cell_handle[g+1];
			assign up_count  = cell_count[g+1];
		end

		if (g == 0) begin : g_first
			assign below_hit = 1'b0;
		end else begin : g_rest
			assign below_hit = upto_vec[g-1];
		end

		rht_cell #(
			.IDX         (g),
			.COUNT_WIDTH (COUNT_WIDTH),
			.OCC_WIDTH   (OCC_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.occupancy  (occ_q),
			.up_handle  (up_handle),
			.up_count   (up_count),
			.below_hit  (below_hit),
			.upto_hit   (upto_vec[g]),
			.hit        (hit_vec[g]),
			.cur_handle (cell_handle[g]),
			.cur_count  (cell_count[g])
		);
	end

	// result register, one cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			status_q         <= res_status;
			release_valid_q  <= res_rv;
			release_handle_q <= res_rh;
			ref_count_q      <= res_cnt;
			entry_count_q    <= occ_d;
			last_q           <= res_last;
		end
	end

	assign result_valid   = result_valid_q;
	assign status         = status_q;
	assign release_valid  = release_valid_q;
	assign release_handle = release_handle_q;
	assign ref_count      = ref_count_q;
	assign entry_count    = entry_count_q;
	assign last           = last_q;

`ifndef SYNTH
	// table never holds more entries than cells
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("occupancy beyond table depth");

	// handles are unique, so at most one cell matches
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rht_pkg::ST_UPD) |-> $onehot0(hit_vec))
		else $error("handle matched in more than one cell");

	// add and remove always answer, with the result registered after the update pass
	a_add_rm_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command == rht_pkg::CMD_ADD || command == rht_pkg::CMD_REMOVE))
		|-> ##3 result_valid)
		else $error("add or remove transaction gave no result");

	// a release is flagged exactly on release and purge entries
	a_release_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (release_valid ==
			(status == rht_pkg::STS_RELEASED || status == rht_pkg::STS_PURGE_ENTRY)))
		else $error("release flag disagrees with status");
`endif

endmodule
